[src/adc_temp_vdda_monitor_assert.svh]
// assertion macros shared by the monitor's divider and datapath rtl modules
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ADC_TEMP_VDDA_MONITOR_ASSERT_SVH
`define ADC_TEMP_VDDA_MONITOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ATVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ATVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// expression must never hold
`define ATVM_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[src/atvm_pkg.sv]
// shared types, constants and microcode rom of the supply/temperature monitor
// no dependencies
`default_nettype none

package atvm_pkg;

  // field and datapath widths
  localparam int CODE_W    = 12;
  localparam int SUM_W     = 18;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SLOPE_W   = 16;
  localparam int THR_W     = 16;
  localparam int VDDA_W    = 16;
  localparam int TEMP_W    = 16;
  localparam int MUL_A_W   = 30;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DEN_W     = 34;
  localparam int QUO_W     = 17;
  localparam int STEP_W    = 4;

  localparam int DEF_SAMPLES_PER_BLOCK = 16;
  localparam int CODE_MAX              = 4095;

  // register reset values
  localparam logic [CODE_W-1:0]       RST_VREFINT_MV = 12'd1200;
  localparam logic [CODE_W-1:0]       RST_V25_MV     = 12'd1430;
  localparam logic [SLOPE_W-1:0]      RST_SLOPE      = 16'd4300;
  localparam logic signed [THR_W-1:0] RST_HOT_SET    = 16'sd7000;
  localparam logic signed [THR_W-1:0] RST_HOT_CLEAR  = 16'sd6500;
  localparam logic [THR_W-1:0]        RST_LOW_SET    = 16'd3000;
  localparam logic [THR_W-1:0]        RST_LOW_CLEAR  = 16'd3100;

  // arithmetic constants
  localparam logic [MUL_B_W-1:0]      CENTI_SCALE  = 18'd100000;
  localparam logic [QUO_W-1:0]        TEMP_Q_CLAMP = 17'd100000;
  localparam logic signed [QUO_W:0]   TEMP_OFFSET  = 18'sd2500;
  localparam logic signed [QUO_W:0]   TEMP_HI      = 18'sd32767;
  localparam logic signed [QUO_W:0]   TEMP_LO      = -18'sd32768;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VREFINT   = 3'd0,
    REG_V25       = 3'd1,
    REG_SLOPE     = 3'd2,
    REG_HOT_SET   = 3'd3,
    REG_HOT_CLEAR = 3'd4,
    REG_LOW_SET   = 3'd5,
    REG_LOW_CLEAR = 3'd6
  } cfg_reg_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_VN,
    OP_DIV_V,
    OP_SAVE_VDDA,
    OP_MUL_V25S,
    OP_MUL_TV,
    OP_SUB_DEN,
    OP_MUL_MAG,
    OP_DIV_T,
    OP_SAVE_TEMP,
    OP_OUT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_END,
    C_BAD,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic not_end;
    logic bad;
    logic div_busy;
    logic out_full;
  } status_t;

  localparam step_t ST_WAIT      = 4'd0;
  localparam step_t ST_DIVV_WAIT = 4'd4;
  localparam step_t ST_DIVT_WAIT = 4'd11;
  localparam step_t ST_OUT       = 4'd13;

  // microprogram: one control word per step
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{op: OP_ACCEPT,    cond: C_NOT_END,  target: ST_WAIT};
      4'd1:    w = '{op: OP_NOP,       cond: C_BAD,      target: ST_OUT};
      4'd2:    w = '{op: OP_MUL_VN,    cond: C_NEVER,    target: ST_WAIT};
      4'd3:    w = '{op: OP_DIV_V,     cond: C_NEVER,    target: ST_WAIT};
      4'd4:    w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: ST_DIVV_WAIT};
      4'd5:    w = '{op: OP_SAVE_VDDA, cond: C_NEVER,    target: ST_WAIT};
      4'd6:    w = '{op: OP_MUL_V25S,  cond: C_NEVER,    target: ST_WAIT};
      4'd7:    w = '{op: OP_MUL_TV,    cond: C_NEVER,    target: ST_WAIT};
      4'd8:    w = '{op: OP_SUB_DEN,   cond: C_NEVER,    target: ST_WAIT};
      4'd9:    w = '{op: OP_MUL_MAG,   cond: C_NEVER,    target: ST_WAIT};
      4'd10:   w = '{op: OP_DIV_T,     cond: C_NEVER,    target: ST_WAIT};
      4'd11:   w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: ST_DIVT_WAIT};
      4'd12:   w = '{op: OP_SAVE_TEMP, cond: C_NEVER,    target: ST_WAIT};
      4'd13:   w = '{op: OP_OUT,       cond: C_OUT_FULL, target: ST_OUT};
      default: w = '{op: OP_NOP,       cond: C_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/atvm_div.sv]
// shared restoring divider, one quotient bit per cycle, with early overflow
// detect when the quotient would not fit; depends on atvm_pkg
`default_nettype none

module atvm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [atvm_pkg::PROD_W-1:0]  dividend,
  input  wire logic [atvm_pkg::DEN_W-1:0]   divisor,
  output logic                              busy,
  output logic [atvm_pkg::QUO_W-1:0]        quotient,
  output logic                              overflow
);
  import atvm_pkg::*;

  localparam int HI_W  = PROD_W - QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_r;
  logic             ovf_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r;
  logic [DEN_W-1:0] dvs_r;

  logic [HI_W-1:0]  hi;
  logic             hi_ovf;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // overflow check on the upper dividend bits, then trial subtract
  always_comb begin
    hi     = dividend[PROD_W-1:QUO_W];
    hi_ovf = DEN_W'(hi) >= divisor;
    trial  = {rem_r, low_r[QUO_W-1]};
    fits   = trial >= {1'b0, dvs_r};
    diff   = trial - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      ovf_r  <= hi_ovf;
      busy_r <= !hi_ovf;
      cnt_r  <= CNT_W'(QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(hi);
      low_r <= dividend[QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = low_r;
  assign overflow = ovf_r;

`include "adc_temp_vdda_monitor_assert.svh"

  `ATVM_ASSERT_IMP(a_rem_below_dvs, busy_r, rem_r < dvs_r, "remainder not below divisor")
  `ATVM_ASSERT_NEVER(a_no_restart, start && busy_r, "divider restarted while busy")
  `ATVM_ASSERT_NEVER(a_ovf_not_busy, ovf_r && busy_r, "overflow flagged while iterating")

endmodule

`default_nettype wire

[src/atvm_dp.sv]
// datapath: config registers, block accumulators, multiplier, work registers,
// hysteresis flags and result register; depends on atvm_pkg and atvm_div
`default_nettype none

module atvm_dp #(
  parameter int SAMPLES_PER_BLOCK = atvm_pkg::DEF_SAMPLES_PER_BLOCK
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire atvm_pkg::uword_t                   uword,
  output atvm_pkg::status_t                       status,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [atvm_pkg::CODE_W-1:0]        in_temp_code,
  input  wire logic [atvm_pkg::CODE_W-1:0]        in_vref_code,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_valid_out,
  output logic [atvm_pkg::VDDA_W-1:0]             out_vdda_mv,
  output logic signed [atvm_pkg::TEMP_W-1:0]      out_temp_centi_c,
  output logic                                    out_over_temp,
  output logic                                    out_low_volt,
  input  wire logic                               cfg_we,
  input  wire logic [atvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [atvm_pkg::CFG_W-1:0]         cfg_data
);
  import atvm_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam logic [CNT_W-1:0]   LAST = CNT_W'(SAMPLES_PER_BLOCK - 1);
  localparam logic [MUL_B_W-1:0] VN_K = MUL_B_W'(CODE_MAX * SAMPLES_PER_BLOCK);

  // configuration registers
  logic [CODE_W-1:0]        vrefint_r;
  logic [CODE_W-1:0]        v25_r;
  logic [SLOPE_W-1:0]       slope_r;
  logic signed [THR_W-1:0]  hot_set_r;
  logic signed [THR_W-1:0]  hot_clr_r;
  logic [THR_W-1:0]         low_set_r;
  logic [THR_W-1:0]         low_clr_r;

  // block accumulators and flags
  logic [CNT_W-1:0]         cnt_r;
  logic [SUM_W-1:0]         tsum_r;
  logic [SUM_W-1:0]         vsum_r;
  logic                     bad_r;
  logic                     hot_flag_r;
  logic                     low_flag_r;

  // work registers
  logic [PROD_W-1:0]        p_r;
  logic [MUL_A_W-1:0]       x_r;
  logic                     neg_r;
  logic [MUL_A_W-1:0]       mag_r;
  logic [DEN_W-1:0]         den_r;
  logic [VDDA_W-1:0]        vdda_r;
  logic signed [TEMP_W-1:0] temp_r;

  // result register
  logic                     out_valid_r;
  logic                     out_vo_r;
  logic [VDDA_W-1:0]        out_vdda_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  logic                     out_hot_r;
  logic                     out_low_r;

  logic                     accept;
  logic                     last;
  logic                     item_bad;
  logic                     out_load;
  logic [SLOPE_W-1:0]       slope_eff;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     mul_en;
  logic [PROD_W-1:0]        prod;
  logic signed [MUL_A_W:0]  diff;
  logic [MUL_A_W:0]         diff_abs;
  logic                     div_start;
  logic [PROD_W-1:0]        dividend;
  logic [DEN_W-1:0]         divisor;
  logic                     div_busy;
  logic [QUO_W-1:0]         quo;
  logic                     div_ovf;
  logic [VDDA_W-1:0]        vdda_sat;
  logic [QUO_W-1:0]         q_clamp;
  logic signed [QUO_W:0]    t_wide;
  logic signed [TEMP_W-1:0] temp_sat;
  logic                     hot_nxt;
  logic                     low_nxt;

  // handshake and status
  always_comb begin
    in_ready        = (uword.op == OP_ACCEPT);
    accept          = in_valid && in_ready;
    last            = (cnt_r == LAST);
    item_bad        = (in_temp_code == '0) || (in_temp_code >= CODE_W'(CODE_MAX)) ||
                      (in_vref_code == '0) || (in_vref_code >= CODE_W'(CODE_MAX));
    status.not_end  = !(accept && last);
    status.bad      = bad_r;
    status.div_busy = div_busy;
    status.out_full = out_valid_r && !out_ready;
    out_load        = (uword.op == OP_OUT) && !status.out_full;
  end

  // multiplier operand select
  always_comb begin
    slope_eff = (slope_r == '0) ? SLOPE_W'(1) : slope_r;
    mul_en    = 1'b1;
    unique case (uword.op)
      OP_MUL_VN: begin
        mul_a = MUL_A_W'(vrefint_r);
        mul_b = VN_K;
      end
      OP_MUL_V25S: begin
        mul_a = MUL_A_W'(v25_r);
        mul_b = vsum_r;
      end
      OP_MUL_TV: begin
        mul_a = MUL_A_W'(vrefint_r);
        mul_b = tsum_r;
      end
      OP_SUB_DEN: begin
        mul_a = MUL_A_W'(vsum_r);
        mul_b = MUL_B_W'(slope_eff);
      end
      OP_MUL_MAG: begin
        mul_a = mag_r;
        mul_b = CENTI_SCALE;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // sensed-voltage numerator: v25*S - T*vrefint
  always_comb begin
    diff     = $signed({1'b0, x_r}) - $signed({1'b0, p_r[MUL_A_W-1:0]});
    diff_abs = diff[MUL_A_W] ? MUL_A_W'(1) + ~diff : diff;
  end

  // divider operands with round-half-up bias
  always_comb begin
    div_start = (uword.op == OP_DIV_V) || (uword.op == OP_DIV_T);
    if (uword.op == OP_DIV_V) begin
      dividend = p_r + PROD_W'(vsum_r >> 1);
      divisor  = DEN_W'(vsum_r);
    end else begin
      dividend = p_r + PROD_W'(den_r >> 1);
      divisor  = den_r;
    end
  end

  atvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quo),
    .overflow (div_ovf)
  );

  // saturate quotients
  always_comb begin
    vdda_sat = (div_ovf || quo[QUO_W-1:VDDA_W] != '0) ? '1 : quo[VDDA_W-1:0];
    q_clamp  = (div_ovf || quo > TEMP_Q_CLAMP) ? TEMP_Q_CLAMP : quo;
    t_wide   = neg_r ? TEMP_OFFSET - $signed({1'b0, q_clamp})
                     : $signed({1'b0, q_clamp}) + TEMP_OFFSET;
    priority if (t_wide > TEMP_HI) begin
      temp_sat = TEMP_HI[TEMP_W-1:0];
    end else if (t_wide < TEMP_LO) begin
      temp_sat = TEMP_LO[TEMP_W-1:0];
    end else begin
      temp_sat = t_wide[TEMP_W-1:0];
    end
  end

  // hysteresis, set wins over clear
  always_comb begin
    hot_nxt = hot_flag_r;
    low_nxt = low_flag_r;
    if (!bad_r) begin
      priority if (temp_r >= hot_set_r) begin
        hot_nxt = 1'b1;
      end else if (temp_r <= hot_clr_r) begin
        hot_nxt = 1'b0;
      end
      priority if (vdda_r <= low_set_r) begin
        low_nxt = 1'b1;
      end else if (vdda_r >= low_clr_r) begin
        low_nxt = 1'b0;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vrefint_r <= RST_VREFINT_MV;
      v25_r     <= RST_V25_MV;
      slope_r   <= RST_SLOPE;
      hot_set_r <= RST_HOT_SET;
      hot_clr_r <= RST_HOT_CLEAR;
      low_set_r <= RST_LOW_SET;
      low_clr_r <= RST_LOW_CLEAR;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VREFINT:   vrefint_r <= cfg_data[CODE_W-1:0];
        REG_V25:       v25_r     <= cfg_data[CODE_W-1:0];
        REG_SLOPE:     slope_r   <= cfg_data;
        REG_HOT_SET:   hot_set_r <= $signed(cfg_data);
        REG_HOT_CLEAR: hot_clr_r <= $signed(cfg_data);
        REG_LOW_SET:   low_set_r <= cfg_data;
        REG_LOW_CLEAR: low_clr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // block accumulation, cleared when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      tsum_r     <= '0;
      vsum_r     <= '0;
      bad_r      <= 1'b0;
      hot_flag_r <= 1'b0;
      low_flag_r <= 1'b0;
    end else if (out_load) begin
      cnt_r      <= '0;
      tsum_r     <= '0;
      vsum_r     <= '0;
      bad_r      <= 1'b0;
      hot_flag_r <= hot_nxt;
      low_flag_r <= low_nxt;
    end else if (accept) begin
      cnt_r  <= last ? cnt_r : cnt_r + 1'b1;
      tsum_r <= tsum_r + SUM_W'(in_temp_code);
      vsum_r <= vsum_r + SUM_W'(in_vref_code);
      bad_r  <= bad_r || item_bad;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_r <= prod;
    end
    if (uword.op == OP_MUL_TV) begin
      x_r <= p_r[MUL_A_W-1:0];
    end
    if (uword.op == OP_SUB_DEN) begin
      neg_r <= diff[MUL_A_W];
      mag_r <= diff_abs[MUL_A_W-1:0];
    end
    if (uword.op == OP_MUL_MAG) begin
      den_r <= p_r[DEN_W-1:0];
    end
    if (uword.op == OP_SAVE_VDDA) begin
      vdda_r <= vdda_sat;
    end
    if (uword.op == OP_SAVE_TEMP) begin
      temp_r <= temp_sat;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vo_r   <= !bad_r;
      out_vdda_r <= bad_r ? '0 : vdda_r;
      out_temp_r <= bad_r ? '0 : temp_r;
      out_hot_r  <= hot_nxt;
      out_low_r  <= low_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_out    = out_vo_r;
  assign out_vdda_mv      = out_vdda_r;
  assign out_temp_centi_c = out_temp_r;
  assign out_over_temp    = out_hot_r;
  assign out_low_volt     = out_low_r;

`include "adc_temp_vdda_monitor_assert.svh"

  `ATVM_ASSERT_NXT(a_load_sets_valid, out_load, out_valid_r, "result not presented after load")
  `ATVM_ASSERT_NXT(a_load_clears_block, out_load, (cnt_r == '0) && !bad_r, "block not cleared")
  `ATVM_ASSERT_NXT(a_bad_keeps_flags, out_load && bad_r,
    $stable(hot_flag_r) && $stable(low_flag_r), "bad block changed a flag")

endmodule

`default_nettype wire

[src/atvm_seq.sv]
// microcode sequencer: step counter, control word rom and conditional jumps
// depends on atvm_pkg
`default_nettype none

module atvm_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire atvm_pkg::status_t status,
  output atvm_pkg::uword_t       uword
);
  import atvm_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  // fetch and branch
  always_comb begin
    uword = ucode_rom(step_r);
    unique case (uword.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOT_END:  take = status.not_end;
      C_BAD:      take = status.bad;
      C_DIV_BUSY: take = status.div_busy;
      C_OUT_FULL: take = status.out_full;
      default:    take = 1'b0;
    endcase
    step_nxt = take ? uword.target : step_t'(step_r + 1'b1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[src/adc_temp_vdda_monitor.sv]
// Supply and die-temperature monitor fed by pairs of 12-bit ADC codes.
// Input channel (in_valid/in_ready): one temperature code and one reference
// code per item. N = SAMPLES_PER_BLOCK items form a block; one result item
// (out_valid/out_ready) leaves at each block end, none otherwise.
// Items are taken one per cycle while a block fills. After the last item of a
// good block the sequencer runs the math, with two passes of the shared
// divider (17 quotient bits each), and then raises out_valid; for a block
// with an out-of-range code it skips the math and goes to the output step.
// No items are taken while the math runs or the result waits to be loaded.
// The result sits in an output register: if the receiver stalls, the block
// still accepts the items of the next block, and only waits at the next
// block end until the held result is taken.
// Configuration (cfg_we/cfg_index/cfg_data) writes one register per cycle and
// is meant to change only while the block is idle; unknown indexes are ignored.
// Synchronous reset loads the register defaults, empties the block, clears
// both flags and drops out_valid.
// Depends on atvm_pkg, atvm_seq, atvm_dp and atvm_div.
`default_nettype none

module adc_temp_vdda_monitor #(
  parameter int SAMPLES_PER_BLOCK = atvm_pkg::DEF_SAMPLES_PER_BLOCK
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [atvm_pkg::CODE_W-1:0]        in_temp_code,
  input  wire logic [atvm_pkg::CODE_W-1:0]        in_vref_code,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_valid_out,
  output logic [atvm_pkg::VDDA_W-1:0]             out_vdda_mv,
  output logic signed [atvm_pkg::TEMP_W-1:0]      out_temp_centi_c,
  output logic                                    out_over_temp,
  output logic                                    out_low_volt,
  input  wire logic                               cfg_we,
  input  wire logic [atvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [atvm_pkg::CFG_W-1:0]         cfg_data
);
  import atvm_pkg::*;

  uword_t  uword;
  status_t status;

  // control sequencer
  atvm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .uword  (uword)
  );

  // datapath
  atvm_dp #(
    .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .uword            (uword),
    .status           (status),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_temp_code     (in_temp_code),
    .in_vref_code     (in_vref_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_out    (out_valid_out),
    .out_vdda_mv      (out_vdda_mv),
    .out_temp_centi_c (out_temp_centi_c),
    .out_over_temp    (out_over_temp),
    .out_low_volt     (out_low_volt),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule

`default_nettype wire
